// ----- rtl/gbe_pkg.sv -----
// Shared types and constants for the glyph bitmap expander.
// Used by gbe_ctrl, gbe_dp and glyph_bitmap_expander; depends on nothing.
`timescale 1ns / 1ps

package gbe_pkg;

  // Field widths
  localparam int FONT_W   = 8;
  localparam int WIDTH_W  = 8;
  localparam int COLOR_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int BIT_IDX_W = $clog2(FONT_W);

  // Default pixel depth for the colour registers
  localparam int PIXEL_BITS = 16;

  // Register reset values
  localparam logic [WIDTH_W-1:0] GLYPH_WIDTH_RST = 8'd8;
  localparam logic [COLOR_W-1:0] FORE_COLOR_RST  = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RST  = 16'h0000;

  // Index of the last bit of a font byte
  localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = BIT_IDX_W'(FONT_W - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH = 2'd0,
    REG_FORE_COLOR  = 2'd1,
    REG_BACK_COLOR  = 2'd2
  } cfg_reg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // take a new font byte
    logic gen;   // produce one pixel into the output register
  } gbe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic byte_last;  // the pixel about to be produced ends the byte
  } gbe_status_t;

endpackage

// ----- rtl/gbe_ctrl.sv -----
// Controller state machine of the glyph bitmap expander.
// Depends on gbe_pkg; drives gbe_dp through command and status structs.
`timescale 1ns / 1ps

module gbe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  gbe_pkg::gbe_status_t status,
  output gbe_pkg::gbe_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   gen;
  logic   load;

  // While emitting, a pixel is produced whenever the output register is free or being drained.
  assign gen = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // The next byte is taken while idle or as the current byte's last pixel goes out.
  assign in_tready = (state_r == ST_IDLE) || (gen && status.byte_last);
  assign load      = in_tvalid && in_tready;

  assign cmd.load  = load;
  assign cmd.gen   = gen;
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (gen && status.byte_last) state_nxt = load ? ST_EMIT : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register occupancy
  assign out_valid_nxt = gen || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/gbe_dp.sv -----
// Datapath of the glyph bitmap expander: registers, byte shifter, row counter
// and the pixel output register. Depends on gbe_pkg; controlled by gbe_ctrl.
`timescale 1ns / 1ps

module gbe_dp #(
  parameter int PIXEL_BITS = gbe_pkg::PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gbe_pkg::gbe_cmd_t                   cmd,
  output gbe_pkg::gbe_status_t                status,
  input  logic                                cfg_we,
  input  logic [gbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gbe_pkg::COLOR_W-1:0]         cfg_data,
  input  logic [gbe_pkg::FONT_W-1:0]          font_byte,
  input  logic                                glyph_end,
  output logic [gbe_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                row_done,
  output logic                                byte_done
);

  // Stored colour depth: the pixel depth, capped by the output field
  localparam int CW = (PIXEL_BITS < gbe_pkg::COLOR_W) ? PIXEL_BITS : gbe_pkg::COLOR_W;

  logic [gbe_pkg::WIDTH_W-1:0]   width_r;
  logic [CW-1:0]                 fore_r;
  logic [CW-1:0]                 back_r;
  logic [gbe_pkg::WIDTH_W-1:0]   row_left_r, row_left_nxt;
  logic [gbe_pkg::FONT_W-1:0]    byte_r, byte_nxt;
  logic [gbe_pkg::BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic                          last_r, last_nxt;
  logic [gbe_pkg::COLOR_W-1:0]   pix_r;
  logic                          row_done_r;
  logic                          byte_done_r;

  logic [gbe_pkg::WIDTH_W-1:0]   row_dec;
  logic                          row_end;
  logic                          byte_last;
  logic [CW-1:0]                 color_sel;

  // Current pixel: the top bit of the shifted byte picks the colour.
  assign row_dec   = row_left_r - 1'b1;
  assign row_end   = (row_dec == '0);
  assign byte_last = row_end || (bit_idx_r == gbe_pkg::LAST_BIT_IDX);
  assign color_sel = byte_r[gbe_pkg::FONT_W-1] ? fore_r : back_r;

  assign status.byte_last = byte_last;

  // Byte shifter and bit position; a new byte overrides the shift.
  always_comb begin
    byte_nxt    = byte_r;
    bit_idx_nxt = bit_idx_r;
    last_nxt    = last_r;
    if (cmd.gen) begin
      byte_nxt    = {byte_r[gbe_pkg::FONT_W-2:0], 1'b0};
      bit_idx_nxt = bit_idx_r + 1'b1;
    end
    if (cmd.load) begin
      byte_nxt    = font_byte;
      bit_idx_nxt = '0;
      last_nxt    = glyph_end;
    end
  end

  // Row counter: takes a glyph width write, else reloads at a row end or after the glyph's last byte.
  always_comb begin
    row_left_nxt = row_left_r;
    if (cfg_we && (cfg_index == gbe_pkg::REG_GLYPH_WIDTH)) begin
      row_left_nxt = cfg_data[gbe_pkg::WIDTH_W-1:0];
    end else if (cmd.gen) begin
      if (row_end || (byte_last && last_r)) row_left_nxt = width_r;
      else row_left_nxt = row_dec;
    end
  end

  // Configuration registers and row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= gbe_pkg::GLYPH_WIDTH_RST;
      fore_r     <= gbe_pkg::FORE_COLOR_RST[CW-1:0];
      back_r     <= gbe_pkg::BACK_COLOR_RST[CW-1:0];
      row_left_r <= gbe_pkg::GLYPH_WIDTH_RST;
    end else begin
      row_left_r <= row_left_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gbe_pkg::REG_GLYPH_WIDTH: width_r <= cfg_data[gbe_pkg::WIDTH_W-1:0];
          gbe_pkg::REG_FORE_COLOR:  fore_r  <= cfg_data[CW-1:0];
          gbe_pkg::REG_BACK_COLOR:  back_r  <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Byte payload and pixel output register
  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    bit_idx_r <= bit_idx_nxt;
    last_r    <= last_nxt;
    if (cmd.gen) begin
      pix_r       <= gbe_pkg::COLOR_W'(color_sel);
      row_done_r  <= row_end;
      byte_done_r <= byte_last;
    end
  end

  assign pixel_color = pix_r;
  assign row_done    = row_done_r;
  assign byte_done   = byte_done_r;

endmodule

// ----- rtl/glyph_bitmap_expander.sv -----
// Glyph bitmap expander: turns font matrix bytes into a stream of pixel colours.
// The first pixel of a byte goes from the byte register into the pixel output register.
// Throughput: one pixel per cycle from the single pixel output register while out_tready
// does not stall it; a byte gives 1 to 8 pixels, and the next byte is taken with the last pixel.
// Reset (synchronous, rst_n low): width 8, foreground 0xFFFF, background 0, row restarts.
// Depends on gbe_pkg, gbe_ctrl and gbe_dp.
`timescale 1ns / 1ps

module glyph_bitmap_expander #(
  parameter int PIXEL_BITS = gbe_pkg::PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] font_byte
  input  logic                          in_tlast,   // glyph_end
  // Result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] pixel_color
  output logic                          out_tuser,  // row_done
  output logic                          out_tlast,  // byte_done
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  gbe_pkg::gbe_cmd_t    cmd;
  gbe_pkg::gbe_status_t status;

  // Registers are written whenever presented.
  assign cfg_ready = 1'b1;

  gbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  gbe_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .font_byte   (in_tdata),
    .glyph_end   (in_tlast),
    .pixel_color (out_tdata),
    .row_done    (out_tuser),
    .byte_done   (out_tlast)
  );

endmodule
